// ===== rtl/ssmix_pkg.sv =====
// ----------------------------------------------------------------------------
// ssmix_pkg
// Shared constants, operation codes and the queued operation type of the
// seed sequence pool mixer.
// ----------------------------------------------------------------------------
package ssmix_pkg;

   // pool geometry
   localparam int POOL_WORDS = 4;
   localparam int PIDX_W     = (POOL_WORDS > 1) ? $clog2(POOL_WORDS) : 1;
   localparam int CNT_W      = $clog2(POOL_WORDS + 1);

   localparam logic [CNT_W-1:0]  POOL_CNT  = CNT_W'(POOL_WORDS);
   localparam logic [PIDX_W-1:0] POOL_LAST = PIDX_W'(POOL_WORDS - 1);

   // front-to-back queue geometry
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [QCNT_W-1:0] QUEUE_CNT  = QCNT_W'(QUEUE_DEPTH);
   localparam logic [QPTR_W-1:0] QUEUE_LAST = QPTR_W'(QUEUE_DEPTH - 1);

   // hash constants
   localparam logic [31:0] MIX_INIT   = 32'h43b0_d7e5;
   localparam logic [31:0] MIX_MUL    = 32'h931e_8875;
   localparam logic [31:0] OUT_INIT   = 32'h8b51_f9dd;
   localparam logic [31:0] OUT_MUL    = 32'h58f3_8ded;
   localparam logic [31:0] PAIR_MUL_L = 32'hca01_f9dd;
   localparam logic [31:0] PAIR_MUL_R = 32'h4973_f715;

   // input command codes
   localparam logic CMD_ENTROPY  = 1'b0;
   localparam logic CMD_GENERATE = 1'b1;

   // classified operation kinds
   typedef enum logic [1:0] {
      OP_GEN  = 2'd0,   // hash one pool word out
      OP_FILL = 2'd1,   // hashmix a word into the next empty pool slot
      OP_MIX  = 2'd2    // hashmix a word into every pool word
   } op_kind_type;

   // one queued operation
   typedef struct packed {
      op_kind_type       kind;
      logic [31:0]       word;
      logic [PIDX_W-1:0] widx;    // pool slot for a fill
      logic              reload;  // first word of a stream
      logic              pad;     // stream ends here, pad the rest with zero
   } mix_op_type;

endpackage

// ===== rtl/seed_sequence_pool_mixer.sv =====
// ----------------------------------------------------------------------------
// seed_sequence_pool_mixer
// Entropy pool mixer: hashmixes a stream of entropy words into a four-word
// pool and hashes pool words out as seed words on request.
//
//   channel | direction | handshake         | payload
//   req     | in        | req_valid/stall   | cmd, entropy_word, last_word
//   rsp     | out       | rsp_valid/stall   | seed_word
//
// One multiply per cycle in the back end sets the cost of a word: a generate
// runs steps G1 and G2, a fill word H1 and H2 (again per zero pad word), the
// word that fills the pool adds a cross-mix of every ordered pair of pool
// words, and a word after that runs H1, H2, P1 and P2 per pool word. A
// two-word queue lets the front take words while the back end works. Reset
// clears the pool, queue, stream position and sequencer state. rsp_stall
// holds a generate in the back end until the result register frees.
// ----------------------------------------------------------------------------
module seed_sequence_pool_mixer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [31:0] req_entropy_word,
   input  logic        req_last_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_seed_word
);

   ssmix_pkg::mix_op_type push_op, pop_op;
   logic                  q_push, q_full, q_valid, q_pop;

   ssmix_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_entropy_word (req_entropy_word),
      .req_last_word    (req_last_word),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_op             (push_op)
   );

   ssmix_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_op (push_op),
      .full    (q_full),
      .valid   (q_valid),
      .pop     (q_pop),
      .pop_op  (pop_op)
   );

   ssmix_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_op          (pop_op),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_seed_word (rsp_seed_word)
   );

endmodule

// ===== rtl/ssmix_front.sv =====
// ----------------------------------------------------------------------------
// ssmix_front
// Accepts input words, tracks stream position and turns each word into a
// fill, mix or generate operation for the back end.
// ----------------------------------------------------------------------------
module ssmix_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_cmd,
   input  logic [31:0]           req_entropy_word,
   input  logic                  req_last_word,
   input  logic                  q_full,
   output logic                  q_push,
   output ssmix_pkg::mix_op_type q_op
);

   logic [ssmix_pkg::CNT_W-1:0] words_seen_ff, words_seen_in;
   logic                        cross_mixed_ff, cross_mixed_in;
   logic [ssmix_pkg::CNT_W-1:0] words_next;

   assign req_stall  = q_full;
   assign q_push     = req_valid & ~q_full;
   assign words_next = words_seen_ff + ssmix_pkg::CNT_W'(1);

   // classify the word against the current stream position
   always_comb begin
      q_op.word   = req_entropy_word;
      q_op.widx   = words_seen_ff[ssmix_pkg::PIDX_W-1:0];
      q_op.reload = (words_seen_ff == '0);
      q_op.pad    = req_last_word;
      if (req_cmd == ssmix_pkg::CMD_GENERATE) begin
         q_op.kind = ssmix_pkg::OP_GEN;
      end else if (!cross_mixed_ff) begin
         q_op.kind = ssmix_pkg::OP_FILL;
      end else begin
         q_op.kind = ssmix_pkg::OP_MIX;
      end
   end

   // stream position update
   always_comb begin
      words_seen_in  = words_seen_ff;
      cross_mixed_in = cross_mixed_ff;
      if (q_push && req_cmd == ssmix_pkg::CMD_ENTROPY) begin
         if (!cross_mixed_ff) begin
            if (words_next >= ssmix_pkg::POOL_CNT) begin
               words_seen_in  = ssmix_pkg::POOL_CNT;
               cross_mixed_in = 1'b1;
            end else begin
               words_seen_in = words_next;
            end
         end
         if (req_last_word) begin
            words_seen_in  = '0;
            cross_mixed_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         words_seen_ff  <= '0;
         cross_mixed_ff <= 1'b0;
      end else begin
         words_seen_ff  <= words_seen_in;
         cross_mixed_ff <= cross_mixed_in;
      end
   end

endmodule

// ===== rtl/ssmix_queue.sv =====
// ----------------------------------------------------------------------------
// ssmix_queue
// Short FIFO of classified operations between front and back end.
// ----------------------------------------------------------------------------
module ssmix_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ssmix_pkg::mix_op_type push_op,
   output logic                  full,
   output logic                  valid,
   input  logic                  pop,
   output ssmix_pkg::mix_op_type pop_op
);

   ssmix_pkg::mix_op_type       entry_ff [ssmix_pkg::QUEUE_DEPTH];
   logic [ssmix_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ssmix_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ssmix_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                         do_push, do_pop;

   assign full    = (count_ff == ssmix_pkg::QUEUE_CNT);
   assign valid   = (count_ff != '0);
   assign pop_op  = entry_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & valid;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == ssmix_pkg::QUEUE_LAST) ? '0
                   : wr_ptr_ff + ssmix_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == ssmix_pkg::QUEUE_LAST) ? '0
                   : rd_ptr_ff + ssmix_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + ssmix_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - ssmix_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// ===== rtl/ssmix_back.sv =====
// ----------------------------------------------------------------------------
// ssmix_back
// Executes queued operations on the pool with one shared 32x32 multiplier,
// one multiply per cycle, and holds the result word register.
// ----------------------------------------------------------------------------
module ssmix_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  ssmix_pkg::mix_op_type q_op,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [31:0]           rsp_seed_word
);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b000_0001,
      ST_H1   = 7'b000_0010,   // advance mix constant, xor input
      ST_H2   = 7'b000_0100,   // multiply by new mix constant
      ST_P1   = 7'b000_1000,   // left pair product
      ST_P2   = 7'b001_0000,   // right pair product, subtract, write
      ST_G1   = 7'b010_0000,   // advance output constant, xor pool word
      ST_G2   = 7'b100_0000    // multiply, emit seed word
   } state_type;

   state_type                    state_ff, state_in;
   logic [31:0]                  pool_ff [ssmix_pkg::POOL_WORDS];
   logic [31:0]                  mhc_ff, mhc_in;
   logic [31:0]                  ohc_ff, ohc_in;
   logic [ssmix_pkg::PIDX_W-1:0] oidx_ff, oidx_in;
   ssmix_pkg::op_kind_type       kind_ff, kind_in;
   logic [31:0]                  word_ff, word_in;
   logic [ssmix_pkg::PIDX_W-1:0] widx_ff, widx_in;
   logic                         pad_ff, pad_in;
   logic                         in_cross_ff, in_cross_in;
   logic [ssmix_pkg::CNT_W-1:0]  src_ff, src_in;
   logic [ssmix_pkg::CNT_W-1:0]  dst_ff, dst_in;
   logic [31:0]                  hv_ff, hv_in;
   logic [31:0]                  tmp_ff, tmp_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [31:0]                  rsp_word_ff, rsp_word_in;

   logic [31:0]                  mul_a, mul_b, prod, prod_mix, diff;
   logic [ssmix_pkg::PIDX_W-1:0] rd_addr, wr_addr;
   logic [31:0]                  pool_rd, wr_data;
   logic                         wr_en;
   logic [ssmix_pkg::CNT_W-1:0]  dst_step, src_step;
   logic                         out_busy;

   // shared multiplier and its post-mix
   assign prod     = mul_a * mul_b;
   assign prod_mix = prod ^ (prod >> 16);
   assign diff     = tmp_ff - prod;
   assign pool_rd  = pool_ff[rd_addr];
   assign out_busy = rsp_valid_ff & rsp_stall;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_seed_word = rsp_word_ff;

   // cross-mix pair walk: next dst skips src
   always_comb begin
      dst_step = dst_ff + ssmix_pkg::CNT_W'(1);
      if (dst_step == src_ff) begin
         dst_step = dst_ff + ssmix_pkg::CNT_W'(2);
      end
      src_step = src_ff + ssmix_pkg::CNT_W'(1);
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      mhc_in       = mhc_ff;
      ohc_in       = ohc_ff;
      oidx_in      = oidx_ff;
      kind_in      = kind_ff;
      word_in      = word_ff;
      widx_in      = widx_ff;
      pad_in       = pad_ff;
      in_cross_in  = in_cross_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      hv_in        = hv_ff;
      tmp_in       = tmp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_word_in  = rsp_word_ff;
      q_pop        = 1'b0;
      mul_a        = hv_ff;
      mul_b        = mhc_ff;
      rd_addr      = dst_ff[ssmix_pkg::PIDX_W-1:0];
      wr_en        = 1'b0;
      wr_addr      = dst_ff[ssmix_pkg::PIDX_W-1:0];
      wr_data      = prod_mix;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop       = 1'b1;
               kind_in     = q_op.kind;
               word_in     = q_op.word;
               widx_in     = q_op.widx;
               pad_in      = q_op.pad;
               in_cross_in = 1'b0;
               src_in      = '0;
               dst_in      = '0;
               unique case (q_op.kind)
                  ssmix_pkg::OP_GEN: begin
                     state_in = ST_G1;
                  end
                  ssmix_pkg::OP_FILL: begin
                     if (q_op.reload) begin
                        mhc_in = ssmix_pkg::MIX_INIT;
                     end
                     state_in = ST_H1;
                  end
                  ssmix_pkg::OP_MIX: begin
                     state_in = ST_H1;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_H1: begin
            rd_addr  = src_ff[ssmix_pkg::PIDX_W-1:0];
            mul_a    = mhc_ff;
            mul_b    = ssmix_pkg::MIX_MUL;
            mhc_in   = prod;
            hv_in    = (in_cross_ff ? pool_rd : word_ff) ^ mhc_ff;
            state_in = ST_H2;
         end

         ST_H2: begin
            mul_a = hv_ff;
            mul_b = mhc_ff;
            if (kind_ff == ssmix_pkg::OP_FILL && !in_cross_ff) begin
               // store into the next pool slot
               wr_en   = 1'b1;
               wr_addr = widx_ff;
               if (widx_ff == ssmix_pkg::POOL_LAST) begin
                  if (ssmix_pkg::POOL_WORDS > 1) begin
                     in_cross_in = 1'b1;
                     src_in      = '0;
                     dst_in      = ssmix_pkg::CNT_W'(1);
                     state_in    = ST_H1;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else if (pad_ff) begin
                  widx_in  = widx_ff + ssmix_pkg::PIDX_W'(1);
                  word_in  = '0;
                  state_in = ST_H1;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               hv_in    = prod_mix;
               state_in = ST_P1;
            end
         end

         ST_P1: begin
            mul_a    = ssmix_pkg::PAIR_MUL_L;
            mul_b    = pool_rd;
            tmp_in   = prod;
            state_in = ST_P2;
         end

         ST_P2: begin
            mul_a   = ssmix_pkg::PAIR_MUL_R;
            mul_b   = hv_ff;
            wr_en   = 1'b1;
            wr_data = diff ^ (diff >> 16);
            if (in_cross_ff) begin
               if (dst_step < ssmix_pkg::POOL_CNT) begin
                  dst_in   = dst_step;
                  state_in = ST_H1;
               end else if (src_step == ssmix_pkg::POOL_CNT) begin
                  state_in = ST_IDLE;
               end else begin
                  src_in   = src_step;
                  dst_in   = '0;
                  state_in = ST_H1;
               end
            end else begin
               if (dst_ff + ssmix_pkg::CNT_W'(1) == ssmix_pkg::POOL_CNT) begin
                  state_in = ST_IDLE;
               end else begin
                  dst_in   = dst_ff + ssmix_pkg::CNT_W'(1);
                  state_in = ST_H1;
               end
            end
         end

         ST_G1: begin
            rd_addr  = oidx_ff;
            mul_a    = ohc_ff;
            mul_b    = ssmix_pkg::OUT_MUL;
            ohc_in   = prod;
            hv_in    = pool_rd ^ ohc_ff;
            state_in = ST_G2;
         end

         ST_G2: begin
            mul_a = hv_ff;
            mul_b = ohc_ff;
            if (!out_busy) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = prod_mix;
               oidx_in      = (oidx_ff == ssmix_pkg::POOL_LAST) ? '0
                            : oidx_ff + ssmix_pkg::PIDX_W'(1);
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and hash state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mhc_ff       <= ssmix_pkg::MIX_INIT;
         ohc_ff       <= ssmix_pkg::OUT_INIT;
         oidx_ff      <= '0;
         in_cross_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mhc_ff       <= mhc_in;
         ohc_ff       <= ohc_in;
         oidx_ff      <= oidx_in;
         in_cross_ff  <= in_cross_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      word_ff     <= word_in;
      widx_ff     <= widx_in;
      pad_ff      <= pad_in;
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      hv_ff       <= hv_in;
      tmp_ff      <= tmp_in;
      rsp_word_ff <= rsp_word_in;
   end

   // pool words, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ssmix_pkg::POOL_WORDS; i++) begin
            pool_ff[i] <= '0;
         end
      end else if (wr_en) begin
         pool_ff[wr_addr] <= wr_data;
      end
   end

endmodule
